/* design/hpr_pkg.sv */
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types, codes and defaults of the horizontal polyphase resampler.
// ----------------------------------------------------------------------------
package hpr_pkg;

  // default sizing
  localparam int TAPS_DEF        = 8;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int MAX_COLS_DEF    = 4096;
  localparam int WEIGHT_SETS_DEF = 64;

  // fixed field widths
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 13;
  localparam int PIXEL_W  = 8;
  localparam int START_W  = 13;
  localparam int SET_W    = 6;
  localparam int TAP_W    = 3;
  localparam int WEIGHT_W = 16;
  localparam int ROW_W    = 12;
  localparam int ADDR_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int COLS_W     = 13;
  localparam int BLK_COLS_W = 10;

  // output buffer layout: 8-row bands of 8x8 byte blocks
  localparam int BAND_SHIFT = 6;
  localparam int COL_SHIFT  = 3;
  localparam int ROW_IN_BLK = 3;
  localparam logic [ROW_IN_BLK-1:0] ROW_MASK = 3'h7;
  localparam int PIXEL_MAX  = 255;

  // register reset values
  localparam logic [COLS_W-1:0]     IN_COLS_RST      = 13'd4096;
  localparam logic [COLS_W-1:0]     OUT_COLS_RST     = 13'd4096;
  localparam logic                  COL_UPSCALE_RST  = 1'b0;
  localparam logic [BLK_COLS_W-1:0] OUT_BLK_COLS_RST = 10'd512;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_PIXEL  = 2'd0,
    OP_LOAD_POINT  = 2'd1,
    OP_LOAD_WEIGHT = 2'd2,
    OP_COMPUTE     = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_COLS      = 2'd0,
    CFG_OUT_COLS     = 2'd1,
    CFG_COL_UPSCALE  = 2'd2,
    CFG_OUT_BLK_COLS = 2'd3
  } cfg_reg_t;

  // one tap issued to the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic ok;
  } tap_issue_t;

endpackage

/* design/hpr_ram.sv */
// ----------------------------------------------------------------------------
// hpr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/hpr_mac.sv */
// ----------------------------------------------------------------------------
// hpr_mac
// Tap multiply-accumulate with final rounding shift and clamp to a byte.
// ----------------------------------------------------------------------------
module hpr_mac #(
  parameter int TAPS      = hpr_pkg::TAPS_DEF,
  parameter int FRAC_BITS = hpr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  hpr_pkg::tap_issue_t                 issue,
  input  logic [hpr_pkg::PIXEL_W-1:0]         pixel,
  input  logic signed [hpr_pkg::WEIGHT_W-1:0] weight,
  output logic                                busy,
  output logic [hpr_pkg::PIXEL_W-1:0]         result
);

  localparam int PROD_W = hpr_pkg::PIXEL_W + 1 + hpr_pkg::WEIGHT_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);

  hpr_pkg::tap_issue_t    issue_d1;
  logic                   prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W:0]    shifted;

  // memory data arrives in the cycle after the issue
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_d1   <= '0;
      prod_valid <= 1'b0;
    end else begin
      issue_d1   <= issue;
      prod_valid <= issue_d1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_d1.ok) begin
      prod <= PROD_W'($signed({1'b0, pixel})) * PROD_W'(weight);
    end else begin
      prod <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = issue_d1.valid | prod_valid;

  // floor shift, so negative sums end up clamped to zero
  always_comb begin
    rnd     = (ACC_W+1)'(acc) + ((ACC_W+1)'(1) <<< (FRAC_BITS - 1));
    shifted = rnd >>> FRAC_BITS;
    if (shifted < 0) begin
      result = '0;
    end else if (shifted > (ACC_W+1)'(hpr_pkg::PIXEL_MAX)) begin
      result = hpr_pkg::PIXEL_W'(hpr_pkg::PIXEL_MAX);
    end else begin
      result = shifted[hpr_pkg::PIXEL_W-1:0];
    end
  end

endmodule

/* design/horizontal_polyphase_resampler_core.sv */
// ----------------------------------------------------------------------------
// horizontal_polyphase_resampler_core
// Horizontal polyphase image resampler over a line store, point table and
// weight store, emitting filtered bytes in block-column order.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   cfg      | cfg_write           | cfg_index, cfg_data
//   in       | in_valid / in_stall | opcode, index, pixel_in, start_col,
//            |                     | weight_set, tap, weight, row
//   out      | out_valid/out_stall | out_address, out_pixel
//
// a load item does not stall the input; a compute item stalls it for the
// point table read, one tap per cycle through the single multiply-accumulate
// unit, then the drain of the memory read and product registers.
// the stores are not cleared by reset; reset only clears control and config.
// a stalled result holds in the output register; a finished compute waits in
// drain until that register is free, with in_stall high.
// ----------------------------------------------------------------------------
module horizontal_polyphase_resampler_core #(
  parameter int TAPS        = hpr_pkg::TAPS_DEF,
  parameter int FRAC_BITS   = hpr_pkg::FRAC_BITS_DEF,
  parameter int MAX_COLS    = hpr_pkg::MAX_COLS_DEF,
  parameter int WEIGHT_SETS = hpr_pkg::WEIGHT_SETS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hpr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [hpr_pkg::OPCODE_W-1:0]         opcode,
  input  logic [hpr_pkg::INDEX_W-1:0]          index,
  input  logic [hpr_pkg::PIXEL_W-1:0]          pixel_in,
  input  logic signed [hpr_pkg::START_W-1:0]   start_col,
  input  logic [hpr_pkg::SET_W-1:0]            weight_set,
  input  logic [hpr_pkg::TAP_W-1:0]            tap,
  input  logic signed [hpr_pkg::WEIGHT_W-1:0]  weight,
  input  logic [hpr_pkg::ROW_W-1:0]            row,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hpr_pkg::ADDR_W-1:0]           out_address,
  output logic [hpr_pkg::PIXEL_W-1:0]          out_pixel
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int POINTS = 2 * MAX_COLS;
  localparam int PT_W   = COL_W + 1;
  localparam int WDEPTH = WEIGHT_SETS * TAPS;
  localparam int WA_W   = $clog2(WDEPTH);
  localparam int KW     = $clog2(TAPS);
  localparam int PT_DW  = hpr_pkg::START_W + hpr_pkg::SET_W;
  localparam int TC_W   = hpr_pkg::START_W + 2;
  localparam int BLK_W  = hpr_pkg::ROW_W - hpr_pkg::ROW_IN_BLK + hpr_pkg::BLK_COLS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POINT = 4'b0010,
    S_TAPS  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [hpr_pkg::COLS_W-1:0]     in_cols;
  logic [hpr_pkg::COLS_W-1:0]     out_cols;
  logic                           col_upscale;
  logic [hpr_pkg::BLK_COLS_W-1:0] out_blk_cols;

  logic                            accept;
  logic                            is_compute;
  logic [hpr_pkg::INDEX_W-1:0]     src_col;
  logic [PT_W-1:0]                 pt_raddr;
  logic [PT_DW-1:0]                pt_rdata;
  logic [BLK_W-1:0]                band_prod;
  logic [hpr_pkg::ADDR_W-1:0]      addr_calc;
  logic [hpr_pkg::ADDR_W-1:0]      addr_r;
  logic signed [hpr_pkg::START_W-1:0] start_r;
  logic [WA_W-1:0]                 wbase;
  logic                            set_ok;
  logic [KW-1:0]                   k;
  logic [TC_W-1:0]                 tcol;
  logic [TC_W-2:0]                 ccol;
  logic                            col_ok;
  logic [hpr_pkg::PIXEL_W-1:0]     line_rdata;
  logic [hpr_pkg::WEIGHT_W-1:0]    w_rdata;
  logic [WA_W-1:0]                 w_waddr;
  hpr_pkg::tap_issue_t             issue;
  logic                            mac_busy;
  logic [hpr_pkg::PIXEL_W-1:0]     mac_result;
  logic                            out_free;
  logic                            out_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cols      <= hpr_pkg::IN_COLS_RST;
      out_cols     <= hpr_pkg::OUT_COLS_RST;
      col_upscale  <= hpr_pkg::COL_UPSCALE_RST;
      out_blk_cols <= hpr_pkg::OUT_BLK_COLS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hpr_pkg::CFG_IN_COLS:      in_cols      <= cfg_data;
        hpr_pkg::CFG_OUT_COLS:     out_cols     <= cfg_data;
        hpr_pkg::CFG_COL_UPSCALE:  col_upscale  <= cfg_data[0];
        hpr_pkg::CFG_OUT_BLK_COLS: out_blk_cols <= cfg_data[hpr_pkg::BLK_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_compute = (opcode == hpr_pkg::OP_COMPUTE);

  // columns past the valid count repeat the last valid one
  always_comb begin
    if (index >= out_cols) begin
      src_col = (out_cols == '0) ? '0 : out_cols - 1'b1;
    end else begin
      src_col = index;
    end
  end

  assign pt_raddr  = PT_W'(32'(src_col) << col_upscale);
  assign band_prod = BLK_W'(row[hpr_pkg::ROW_W-1:hpr_pkg::ROW_IN_BLK]) * BLK_W'(out_blk_cols);
  assign addr_calc = hpr_pkg::ADDR_W'(32'(band_prod) << hpr_pkg::BAND_SHIFT)
                   + hpr_pkg::ADDR_W'(32'(index) << hpr_pkg::COL_SHIFT)
                   + hpr_pkg::ADDR_W'(row[hpr_pkg::ROW_IN_BLK-1:0] & hpr_pkg::ROW_MASK);

  assign w_waddr = WA_W'(32'(index) * TAPS + 32'(tap));

  hpr_ram #(
    .WIDTH (hpr_pkg::PIXEL_W),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (accept && opcode == hpr_pkg::OP_LOAD_PIXEL && 32'(index) < MAX_COLS),
    .waddr (COL_W'(index)),
    .wdata (pixel_in),
    .re    (issue.valid),
    .raddr (COL_W'(ccol)),
    .rdata (line_rdata)
  );

  hpr_ram #(
    .WIDTH (PT_DW),
    .DEPTH (POINTS)
  ) u_point (
    .clk   (clk),
    .we    (accept && opcode == hpr_pkg::OP_LOAD_POINT && 32'(index) < POINTS),
    .waddr (PT_W'(index)),
    .wdata ({start_col, weight_set}),
    .re    (accept && is_compute),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  hpr_ram #(
    .WIDTH (hpr_pkg::WEIGHT_W),
    .DEPTH (WDEPTH)
  ) u_weight (
    .clk   (clk),
    .we    (accept && opcode == hpr_pkg::OP_LOAD_WEIGHT && 32'(index) < WEIGHT_SETS
            && 32'(tap) < TAPS),
    .waddr (w_waddr),
    .wdata (weight),
    .re    (issue.valid),
    .raddr (wbase + WA_W'(k)),
    .rdata (w_rdata)
  );

  // tap column, halved for upscaled chroma
  assign tcol   = {{2{start_r[hpr_pkg::START_W-1]}}, start_r} + TC_W'(k);
  assign ccol   = tcol[TC_W-2:0] >> col_upscale;
  assign col_ok = !tcol[TC_W-1] && (ccol < {1'b0, in_cols}) && (32'(ccol) < MAX_COLS);

  assign issue.valid = (state == S_TAPS);
  assign issue.ok    = (state == S_TAPS) && set_ok && col_ok;

  hpr_mac #(
    .TAPS      (TAPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (state == S_POINT),
    .issue  (issue),
    .pixel  (line_rdata),
    .weight ($signed(w_rdata)),
    .busy   (mac_busy),
    .result (mac_result)
  );

  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DRAIN) && !mac_busy && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && is_compute) state_next = S_POINT;
      S_POINT: state_next = S_TAPS;
      S_TAPS:  if (k == KW'(TAPS - 1)) state_next = S_DRAIN;
      S_DRAIN: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == S_POINT) begin
        k <= '0;
      end else if (state == S_TAPS) begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_compute) begin
      addr_r <= addr_calc;
    end
    if (state == S_POINT) begin
      start_r <= $signed(pt_rdata[PT_DW-1:hpr_pkg::SET_W]);
      wbase   <= WA_W'(32'(pt_rdata[hpr_pkg::SET_W-1:0]) * TAPS);
      set_ok  <= 32'(pt_rdata[hpr_pkg::SET_W-1:0]) < WEIGHT_SETS;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_address <= addr_r;
      out_pixel   <= mac_result;
    end
  end

endmodule

/* design/hpr_checker.sv */
// ----------------------------------------------------------------------------
// hpr_port_checks
// Port-level checks of the resampler core, bound to the top level.
// ----------------------------------------------------------------------------
module hpr_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [hpr_pkg::OPCODE_W-1:0]   opcode,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [hpr_pkg::ADDR_W-1:0]     out_address,
  input logic [hpr_pkg::PIXEL_W-1:0]    out_pixel
);

  // a compute transfer occupies the core on the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == hpr_pkg::OP_COMPUTE |=> in_stall)
    else $error("input not stalled after compute transfer");

  // loads never make a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode != hpr_pkg::OP_COMPUTE && !out_valid |=> !out_valid)
    else $error("result appeared after a load transfer");

  // an idle core has no result on its way
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_address) && $stable(out_pixel))
    else $error("stalled result changed");

endmodule

bind horizontal_polyphase_resampler_core hpr_port_checks u_hpr_port_checks (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .opcode      (opcode),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_address (out_address),
  .out_pixel   (out_pixel)
);

/* verif/hpr_checker.sv */
// ----------------------------------------------------------------------------
// hpr_checker
// Watches the config, input and output channels of the resampler core. It
// keeps its own copy of the line store, point table, weight store and
// registers, works out the byte and address each compute transfer must give,
// and compares every output transfer against the oldest one still owed.
// ----------------------------------------------------------------------------
module hpr_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [hpr_pkg::OPCODE_W-1:0]        opcode,
  input  logic [hpr_pkg::INDEX_W-1:0]         index,
  input  logic [hpr_pkg::PIXEL_W-1:0]         pixel_in,
  input  logic signed [hpr_pkg::START_W-1:0]  start_col,
  input  logic [hpr_pkg::SET_W-1:0]           weight_set,
  input  logic [hpr_pkg::TAP_W-1:0]           tap,
  input  logic signed [hpr_pkg::WEIGHT_W-1:0] weight,
  input  logic [hpr_pkg::ROW_W-1:0]           row,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [hpr_pkg::ADDR_W-1:0]          out_address,
  input  logic [hpr_pkg::PIXEL_W-1:0]         out_pixel,
  output int                                  fails,
  output int                                  pending,
  output int                                  checked
);
  import hpr_pkg::*;

  localparam int TAPS        = TAPS_DEF;
  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int MAX_COLS    = MAX_COLS_DEF;
  localparam int WEIGHT_SETS = WEIGHT_SETS_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] pixel;
  } resized_px_t;

  logic [PIXEL_W-1:0]         line_px  [MAX_COLS];
  logic signed [START_W-1:0]  pt_first [2*MAX_COLS];
  logic [SET_W-1:0]           pt_set   [2*MAX_COLS];
  logic signed [WEIGHT_W-1:0] coef     [WEIGHT_SETS*TAPS];

  logic [COLS_W-1:0]     in_cols_q;
  logic [COLS_W-1:0]     out_cols_q;
  logic                  upscale_q;
  logic [BLK_COLS_W-1:0] blk_cols_q;

  resized_px_t owed_q [$];

  initial begin
    fails   = 0;
    pending = 0;
    checked = 0;
  end

  function automatic logic [PIXEL_W-1:0] filter_at(input logic [INDEX_W-1:0] col);
    logic [INDEX_W-1:0] pt;
    int                 base;
    int                 k;
    int                 t;
    int                 c;
    longint             acc;
    // point index wraps at the table size through the 13-bit truncation
    pt   = col << upscale_q;
    base = int'(pt_set[pt]) * TAPS;
    acc  = 0;
    for (k = 0; k < TAPS; k++) begin
      t = int'(pt_first[pt]) + k;
      if (t < 0) continue;
      c = t >> upscale_q;
      if (c >= int'(in_cols_q) || c >= MAX_COLS) continue;
      acc += longint'(line_px[c]) * longint'(coef[base + k]);
    end
    // arithmetic shift gives floor rounding for negative sums
    acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (acc < 0) return '0;
    if (acc > PIXEL_MAX) return PIXEL_W'(PIXEL_MAX);
    return PIXEL_W'(acc);
  endfunction

  function automatic resized_px_t resize_out(input logic [INDEX_W-1:0] col,
                                             input logic [ROW_W-1:0]   rw);
    resized_px_t        res;
    logic [INDEX_W-1:0] src;
    logic [31:0]        a;
    // columns past the valid count repeat the last valid one
    src = col;
    if (col >= out_cols_q) src = (out_cols_q == 0) ? '0 : INDEX_W'(out_cols_q - 1'b1);
    a = 32'(rw >> ROW_IN_BLK) * (32'(blk_cols_q) << BAND_SHIFT)
      + (32'(col) << COL_SHIFT) + 32'(rw & ROW_MASK);
    res.addr  = a[ADDR_W-1:0];
    res.pixel = filter_at(src);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    resized_px_t want;
    if (rst) begin
      in_cols_q  = IN_COLS_RST;
      out_cols_q = OUT_COLS_RST;
      upscale_q  = COL_UPSCALE_RST;
      blk_cols_q = OUT_BLK_COLS_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          CFG_IN_COLS:      in_cols_q  = cfg_data;
          CFG_OUT_COLS:     out_cols_q = cfg_data;
          CFG_COL_UPSCALE:  upscale_q  = cfg_data[0];
          CFG_OUT_BLK_COLS: blk_cols_q = cfg_data[BLK_COLS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          fails++;
          $display("%0t: output transfer with nothing owed, address %0h pixel %0d",
                   $time, out_address, out_pixel);
        end else begin
          want = owed_q.pop_front();
          checked++;
          if (out_address !== want.addr) begin
            fails++;
            $display("%0t: out_address expected %0h got %0h", $time, want.addr, out_address);
          end
          if (out_pixel !== want.pixel) begin
            fails++;
            $display("%0t: out_pixel expected %0d got %0d", $time, want.pixel, out_pixel);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (opcode_t'(opcode))
          OP_LOAD_PIXEL: begin
            if (int'(index) < MAX_COLS) line_px[index] = pixel_in;
          end
          OP_LOAD_POINT: begin
            if (int'(index) < 2 * MAX_COLS) begin
              pt_first[index] = start_col;
              pt_set[index]   = weight_set;
            end
          end
          OP_LOAD_WEIGHT: begin
            if (int'(index) < WEIGHT_SETS && int'(tap) < TAPS)
              coef[int'(index) * TAPS + int'(tap)] = weight;
          end
          OP_COMPUTE: owed_q.push_back(resize_out(index, row));
          default: ;
        endcase
      end
    end
    pending = owed_q.size();
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the horizontal resampler core. Loads are issued
// just ahead of each compute so that no store entry is read before it was
// written; random phases sweep register settings, gaps and output stalls,
// while the checker beside the core predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import hpr_pkg::*;

  localparam int TAPS        = TAPS_DEF;
  localparam int MAX_COLS    = MAX_COLS_DEF;
  localparam int WEIGHT_SETS = WEIGHT_SETS_DEF;
  localparam int SETTLE      = TAPS + 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    opcode_t                    op;
    logic [INDEX_W-1:0]         idx;
    logic [PIXEL_W-1:0]         pix;
    logic signed [START_W-1:0]  first;
    logic [SET_W-1:0]           set;
    logic [TAP_W-1:0]           tp;
    logic signed [WEIGHT_W-1:0] w;
    logic [ROW_W-1:0]           rw;
  } resize_req_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        opcode;
  logic [INDEX_W-1:0]         index;
  logic [PIXEL_W-1:0]         pixel_in;
  logic signed [START_W-1:0]  start_col;
  logic [SET_W-1:0]           weight_set;
  logic [TAP_W-1:0]           tap;
  logic signed [WEIGHT_W-1:0] weight;
  logic [ROW_W-1:0]           row;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ADDR_W-1:0]          out_address;
  logic [PIXEL_W-1:0]         out_pixel;

  int fails;
  int pending;
  int checked;

  // what the stores hold so far, so every compute can be primed first
  bit pix_known [MAX_COLS];
  bit pt_known  [2*MAX_COLS];
  int pt_first_sh [2*MAX_COLS];
  int pt_set_sh   [2*MAX_COLS];
  bit wt_known  [WEIGHT_SETS*TAPS];

  logic [COLS_W-1:0] in_lim  = IN_COLS_RST;
  logic [COLS_W-1:0] out_lim = OUT_COLS_RST;
  bit                upscale = COL_UPSCALE_RST;
  bit                calm    = 1'b1;
  int                sent;
  int                settings;
  int                stall_hold = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  horizontal_polyphase_resampler_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .index       (index),
    .pixel_in    (pixel_in),
    .start_col   (start_col),
    .weight_set  (weight_set),
    .tap         (tap),
    .weight      (weight),
    .row         (row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_address (out_address),
    .out_pixel   (out_pixel)
  );

  hpr_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .index       (index),
    .pixel_in    (pixel_in),
    .start_col   (start_col),
    .weight_set  (weight_set),
    .tap         (tap),
    .weight      (weight),
    .row         (row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_address (out_address),
    .out_pixel   (out_pixel),
    .fails       (fails),
    .pending     (pending),
    .checked     (checked)
  );

  // mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 24);
    return $urandom_range(0, 3);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return idle_len() + 1;
  endfunction

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_hold <= idle_len();
      out_stall  <= !calm && ($urandom_range(0, 2) == 0);
    end
  end

  function automatic logic signed [START_W-1:0] pick_first();
    int span;
    span = int'(in_lim) << upscale;
    if ($urandom_range(0, 3) == 0) return START_W'($urandom);
    return START_W'(int'($urandom_range(0, span + 16)) - 16);
  endfunction

  // weights mostly near unity gain overall, some anywhere in range
  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    if ($urandom_range(0, 3) == 0) return WEIGHT_W'($urandom);
    return WEIGHT_W'(int'($urandom_range(0, 8191)) - 2048);
  endfunction

  // unused payload fields carry random values too
  function automatic resize_req_t rand_req(input opcode_t op);
    resize_req_t r;
    r.op    = op;
    r.idx   = INDEX_W'($urandom);
    r.pix   = PIXEL_W'($urandom);
    r.first = START_W'($urandom);
    r.set   = SET_W'($urandom);
    r.tp    = TAP_W'($urandom);
    r.w     = WEIGHT_W'($urandom);
    r.rw    = ROW_W'($urandom);
    return r;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send(input resize_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode     <= r.op;
    index      <= r.idx;
    pixel_in   <= r.pix;
    start_col  <= r.first;
    weight_set <= r.set;
    tap        <= r.tp;
    weight     <= r.w;
    row        <= r.rw;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (r.op)
      OP_LOAD_PIXEL: begin
        if (int'(r.idx) < MAX_COLS) pix_known[r.idx] = 1'b1;
      end
      OP_LOAD_POINT: begin
        pt_known[r.idx]    = 1'b1;
        pt_first_sh[r.idx] = int'(r.first);
        pt_set_sh[r.idx]   = int'(r.set);
      end
      OP_LOAD_WEIGHT: begin
        if (int'(r.idx) < WEIGHT_SETS) wt_known[int'(r.idx) * TAPS + int'(r.tp)] = 1'b1;
      end
      default: ;
    endcase
    sent++;
  endtask

  task automatic load_pixel(input logic [INDEX_W-1:0] col, input logic [PIXEL_W-1:0] val);
    resize_req_t r;
    r     = rand_req(OP_LOAD_PIXEL);
    r.idx = col;
    r.pix = val;
    send(r);
  endtask

  task automatic load_point(input logic [INDEX_W-1:0] pt, input logic signed [START_W-1:0] first,
                            input logic [SET_W-1:0] set);
    resize_req_t r;
    r       = rand_req(OP_LOAD_POINT);
    r.idx   = pt;
    r.first = first;
    r.set   = set;
    send(r);
  endtask

  task automatic load_weight(input logic [INDEX_W-1:0] set, input logic [TAP_W-1:0] tp,
                             input logic signed [WEIGHT_W-1:0] w);
    resize_req_t r;
    r     = rand_req(OP_LOAD_WEIGHT);
    r.idx = set;
    r.tp  = tp;
    r.w   = w;
    send(r);
  endtask

  // fill whatever the compute will read and has never been written, then compute
  task automatic prime_and_compute(input logic [INDEX_W-1:0] col, input logic [ROW_W-1:0] rw);
    resize_req_t        r;
    logic [INDEX_W-1:0] src;
    logic [INDEX_W-1:0] pt;
    int                 base;
    int                 k;
    int                 t;
    int                 c;
    src = col;
    if (col >= out_lim) src = (out_lim == 0) ? '0 : INDEX_W'(out_lim - 1'b1);
    pt = src << upscale;
    if (!pt_known[pt]) load_point(pt, pick_first(), SET_W'($urandom));
    base = pt_set_sh[pt] * TAPS;
    for (k = 0; k < TAPS; k++) begin
      if (!wt_known[base + k]) load_weight(INDEX_W'(pt_set_sh[pt]), TAP_W'(k), pick_weight());
    end
    for (k = 0; k < TAPS; k++) begin
      t = pt_first_sh[pt] + k;
      if (t >= 0) begin
        c = t >> upscale;
        if (c < int'(in_lim) && c < MAX_COLS && !pix_known[c])
          load_pixel(INDEX_W'(c), PIXEL_W'($urandom));
      end
    end
    r     = rand_req(OP_COMPUTE);
    r.idx = col;
    r.rw  = rw;
    send(r);
  endtask

  // wait out every owed result plus the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] ic, input logic [CFG_DATA_W-1:0] oc,
                            input logic [CFG_DATA_W-1:0] upd, input logic [CFG_DATA_W-1:0] blkd);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IN_COLS;
    cfg_data  <= ic;
    @(posedge clk);
    cfg_index <= CFG_OUT_COLS;
    cfg_data  <= oc;
    @(posedge clk);
    cfg_index <= CFG_COL_UPSCALE;
    cfg_data  <= upd;
    @(posedge clk);
    cfg_index <= CFG_OUT_BLK_COLS;
    cfg_data  <= blkd;
    @(posedge clk);
    cfg_write <= 1'b0;
    in_lim  = ic;
    out_lim = oc;
    upscale = upd[0];
    settings++;
  endtask

  initial begin : stimulus
    int                 p;
    int                 goal;
    int                 pick;
    int                 top_col;
    logic [INDEX_W-1:0] col;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = CFG_IN_COLS;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = OP_LOAD_PIXEL;
    index      = '0;
    pixel_in   = '0;
    start_col  = '0;
    weight_set = '0;
    tap        = '0;
    weight     = '0;
    row        = '0;
    sent       = 0;
    settings   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset register values
    load_pixel(13'd0, 8'd0);
    load_pixel(13'd4095, 8'd255);
    load_pixel(13'd4096, 8'hAA);     // past the line store, dropped
    load_pixel(13'd8191, 8'h55);
    load_weight(13'd0, 3'd0, 16'sh7FFF);
    load_weight(13'd0, 3'd7, 16'sh8000);
    load_weight(13'd63, 3'd3, 16'sd16384);
    load_weight(13'd64, 3'd0, 16'sh1234);   // weight set past the store, dropped
    load_weight(13'd8191, 3'd7, 16'sh8000);
    load_point(13'd0, 13'sh1000, 6'd0);      // every tap left of column 0
    load_point(13'd8191, 13'sd4095, 6'd63);
    load_point(13'd1, -13'sd3, 6'd0);
    load_point(13'd2, 13'sd4090, 6'd63);     // last taps past in_cols
    prime_and_compute(13'd0, 12'd0);
    prime_and_compute(13'd1, 12'd7);
    prime_and_compute(13'd2, 12'd8);
    prime_and_compute(13'd4095, 12'd4095);
    prime_and_compute(13'd8191, 12'd4095);   // edge repeat and address wrap
    settle();
    write_regs(13'd5, 13'd3, 13'h1FFF, 13'h1FFF);
    prime_and_compute(13'd8191, 12'd9);
    prime_and_compute(13'd0, 12'd1);
    settle();
    write_regs(13'd4096, 13'd0, 13'd0, 13'd0);  // zero out_cols repeats column 0
    prime_and_compute(13'd300, 12'd15);
    settle();
    write_regs(13'd4096, 13'd8191, 13'd1, 13'd512);
    prime_and_compute(13'd4097, 12'd0);      // doubled point index wraps
    prime_and_compute(13'd8191, 12'd4095);
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: write_regs(13'd4096, 13'd4096, 13'd0, 13'd512);
        1: write_regs(13'd1, 13'd1, CFG_DATA_W'($urandom) | 13'd1, 13'd1);
        2: write_regs(13'd8191, 13'd8191, 13'd1, 13'd1023);
        3: write_regs(CFG_DATA_W'($urandom_range(1, 64)), 13'd0, CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom_range(1, 1023)));
        default: write_regs(CFG_DATA_W'($urandom_range(1, 300)),
                            CFG_DATA_W'($urandom_range(1, 400)), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom_range(1, 1023))
                            | (CFG_DATA_W'($urandom) & 13'h1C00));
      endcase
      calm = (p == 2 || p == 5);
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        pick    = $urandom_range(0, 19);
        top_col = (out_lim == 0) ? 0 : int'(out_lim) - 1;
        if (pick < 11) begin
          if ($urandom_range(0, 4) == 0) col = INDEX_W'($urandom);
          else col = INDEX_W'($urandom_range(0, top_col));
          prime_and_compute(col, ROW_W'($urandom));
        end else if (pick < 14) begin
          if ($urandom_range(0, 7) == 0) begin
            load_pixel(INDEX_W'($urandom_range(MAX_COLS, 8191)), PIXEL_W'($urandom));
          end else begin
            top_col = (in_lim == 0) ? 0 : int'(in_lim) - 1;
            if (top_col >= MAX_COLS) top_col = MAX_COLS - 1;
            load_pixel(INDEX_W'($urandom_range(0, top_col)), PIXEL_W'($urandom));
          end
        end else if (pick < 17) begin
          col = INDEX_W'($urandom_range(0, top_col));
          load_point(col << upscale, pick_first(), SET_W'($urandom));
        end else begin
          if ($urandom_range(0, 7) == 0)
            load_weight(INDEX_W'($urandom_range(WEIGHT_SETS, 8191)), TAP_W'($urandom),
                        pick_weight());
          else
            load_weight(INDEX_W'($urandom_range(0, WEIGHT_SETS - 1)), TAP_W'($urandom),
                        pick_weight());
        end
      end
      settle();
    end

    $display("transfers in: %0d, results compared: %0d, register settings: %0d",
             sent, checked, settings);
    $display("covered clamping, edge repeat, upscaled chroma, index wrap and dropped loads");
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results still owed", pending);
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
design/hpr_pkg.sv
design/hpr_ram.sv
design/hpr_mac.sv
design/horizontal_polyphase_resampler_core.sv
design/hpr_checker.sv
verif/hpr_checker.sv
verif/testbench.sv
